/* src/tdp_pkg.sv */
`timescale 1ns / 1ps
// tdp_pkg: shared widths, request kind codes and the queue entry type
// for the trial division prime test unit. depends on nothing.
package tdp_pkg;

  localparam int VALUE_WIDTH = 32;
  // non-negative values only ever reach the divider
  localparam int MAG_WIDTH = VALUE_WIDTH - 1;
  // divisor never exceeds sqrt(2^MAG_WIDTH) + 1
  localparam int DIV_WIDTH = (MAG_WIDTH + 2) / 2;
  localparam int SQ_WIDTH = 2 * DIV_WIDTH;
  localparam int CNT_WIDTH = $clog2(MAG_WIDTH);

  typedef enum logic [1:0] {
    KIND_COMPOSITE,
    KIND_PRIME,
    KIND_TEST
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [MAG_WIDTH-1:0]  mag;
  } entry_t;

endpackage

/* src/trial_division_prime_test_unit.sv */
`timescale 1ns / 1ps
// trial division prime test unit: takes one signed value per request and
// returns one is_prime bit for it. depends on tdp_pkg, tdp_front,
// tdp_queue and tdp_back.
//
// input channel: value with in_valid / in_stall; output channel: is_prime
// with out_valid / out_stall. each request gives exactly one result, in
// request order.
// negative values, zero and one report 0; two and three report 1 without
// using the divider. larger values try divisors 2, 3, ... while d*d <= value
// on a single restoring remainder unit that retires one dividend bit a cycle.
// each divisor goes through a square, a bound check and 31 remainder steps.
// the front register and a two-entry queue keep taking requests while the
// divider is busy; in_stall rises once both are full.
// a stalled result stays in the output register; the divider may finish the
// next request and wait behind it.
// reset (rst, synchronous) empties the queue, drops any request in progress
// and clears out_valid.
module trial_division_prime_test_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tdp_pkg::VALUE_WIDTH-1:0]  value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             is_prime
);

  logic             push_valid;
  logic             push_stall;
  tdp_pkg::entry_t  push_entry;
  logic             q_valid;
  logic             q_stall;
  tdp_pkg::entry_t  q_entry;

  tdp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_entry (push_entry)
  );

  tdp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_entry (push_entry),
    .pop_valid  (q_valid),
    .pop_stall  (q_stall),
    .pop_entry  (q_entry)
  );

  tdp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_stall   (q_stall),
    .q_entry   (q_entry),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_prime  (is_prime)
  );

endmodule

/* src/tdp_front.sv */
`timescale 1ns / 1ps
// tdp_front: accepts requests and sorts out the trivial values before the
// divider sees them. depends on tdp_pkg.
module tdp_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tdp_pkg::VALUE_WIDTH-1:0]  value,
  output logic                             push_valid,
  input  logic                             push_stall,
  output tdp_pkg::entry_t                  push_entry
);

  logic             valid;
  tdp_pkg::entry_t  entry;
  tdp_pkg::entry_t  entry_next;

  always_comb begin
    entry_next.mag = value[tdp_pkg::MAG_WIDTH-1:0];
    if (value[tdp_pkg::VALUE_WIDTH-1]) begin
      entry_next.kind = tdp_pkg::KIND_COMPOSITE;
    end else if (value < tdp_pkg::VALUE_WIDTH'(2)) begin
      entry_next.kind = tdp_pkg::KIND_COMPOSITE;
    end else if (value < tdp_pkg::VALUE_WIDTH'(4)) begin
      // two and three have no divisor below their root
      entry_next.kind = tdp_pkg::KIND_PRIME;
    end else begin
      entry_next.kind = tdp_pkg::KIND_TEST;
    end
  end

  assign in_stall   = valid && push_stall;
  assign push_valid = valid;
  assign push_entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      entry <= entry_next;
    end
  end

endmodule

/* src/tdp_queue.sv */
`timescale 1ns / 1ps
// tdp_queue: two-entry queue between the front and the divider sequencer.
// depends on tdp_pkg.
module tdp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_stall,
  input  tdp_pkg::entry_t  push_entry,
  output logic             pop_valid,
  input  logic             pop_stall,
  output tdp_pkg::entry_t  pop_entry
);

  tdp_pkg::entry_t  slots [0:1];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign push_stall = (count == 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_entry  = slots[rptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

endmodule

/* src/tdp_back.sv */
`timescale 1ns / 1ps
// tdp_back: divider sequencer; tries divisors 2, 3, ... on one restoring
// remainder unit and holds the result register. depends on tdp_pkg.
module tdp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_stall,
  input  tdp_pkg::entry_t  q_entry,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             is_prime
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_BOUND,
    S_DIVIDE,
    S_FINISH
  } state_t;

  state_t                          state;
  logic [tdp_pkg::MAG_WIDTH-1:0]   n;
  logic [tdp_pkg::MAG_WIDTH-1:0]   shreg;
  logic [tdp_pkg::DIV_WIDTH-1:0]   d;
  logic [tdp_pkg::SQ_WIDTH-1:0]    sq;
  logic [tdp_pkg::DIV_WIDTH-1:0]   rem;
  logic [tdp_pkg::DIV_WIDTH-1:0]   rem_next;
  logic [tdp_pkg::DIV_WIDTH:0]     trial;
  logic [tdp_pkg::CNT_WIDTH-1:0]   cnt;
  logic                            res;
  logic                            finish_go;

  assign q_stall   = (state != S_IDLE);
  // result register is free or drains this cycle
  assign finish_go = (state == S_FINISH) && (!out_valid || !out_stall);

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, shreg[tdp_pkg::MAG_WIDTH-1]};
    if (trial >= {1'b0, d}) begin
      rem_next = tdp_pkg::DIV_WIDTH'(trial - {1'b0, d});
    end else begin
      rem_next = trial[tdp_pkg::DIV_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (finish_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_entry.kind)
              tdp_pkg::KIND_TEST: begin
                n     <= q_entry.mag;
                d     <= tdp_pkg::DIV_WIDTH'(2);
                state <= S_SQUARE;
              end
              tdp_pkg::KIND_PRIME: begin
                res   <= 1'b1;
                state <= S_FINISH;
              end
              default: begin
                res   <= 1'b0;
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_SQUARE: begin
          sq    <= tdp_pkg::SQ_WIDTH'(d) * tdp_pkg::SQ_WIDTH'(d);
          state <= S_BOUND;
        end
        S_BOUND: begin
          if (sq > tdp_pkg::SQ_WIDTH'(n)) begin
            res   <= 1'b1;
            state <= S_FINISH;
          end else begin
            rem   <= '0;
            shreg <= n;
            cnt   <= '0;
            state <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          rem   <= rem_next;
          shreg <= shreg << 1;
          cnt   <= cnt + tdp_pkg::CNT_WIDTH'(1);
          if (cnt == tdp_pkg::CNT_WIDTH'(tdp_pkg::MAG_WIDTH - 1)) begin
            if (rem_next == '0) begin
              res   <= 1'b0;
              state <= S_FINISH;
            end else begin
              d     <= d + tdp_pkg::DIV_WIDTH'(1);
              state <= S_SQUARE;
            end
          end
        end
        S_FINISH: begin
          if (finish_go) begin
            is_prime <= res;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_divisor_min: assert property (@(posedge clk) disable iff (rst)
    state == S_DIVIDE |-> d >= tdp_pkg::DIV_WIDTH'(2))
    else $error("divisor below two during remainder");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIVIDE |-> rem < d)
    else $error("partial remainder not below divisor");

  a_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_stall |=> state != S_IDLE)
    else $error("request popped but sequencer stayed idle");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("result raised outside finish state");
`endif

endmodule

/* tb/tb_trial_division_prime_test_unit.sv */
`timescale 1ns / 1ps
// testbench for trial_division_prime_test_unit: directed table, then random requests; each
// checked against a typed-in or trial division verdict. depends on tdp_pkg and the unit.
module tb_trial_division_prime_test_unit;
  localparam int VALUE_WIDTH = tdp_pkg::VALUE_WIDTH;

  localparam int RANDOM_REQUESTS = 80;
  // a prime near 2^31 keeps both channels quiet while its divisors are tried
  localparam int QUIET_LIMIT = 5_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT_RESULT = 70;
  localparam int DRAIN_CYCLES = 40;

  typedef logic [VALUE_WIDTH-1:0] word_t;

  typedef struct packed {
    word_t value;
    logic  known;
    logic  verdict;
  } stim_row_t;

  typedef struct packed {
    word_t value;
    logic  is_prime;
  } verdict_t;

  // verdict only typed in where it is plain; other rows go through the predictor
  localparam stim_row_t DIRECTED [21] = '{
    '{32'd0,          1'b1, 1'b0},
    '{32'd1,          1'b1, 1'b0},
    '{32'd2,          1'b1, 1'b1},
    '{32'd3,          1'b1, 1'b1},
    '{32'hFFFF_FFFF,  1'b1, 1'b0},
    '{32'h8000_0000,  1'b1, 1'b0},
    '{32'h8000_0001,  1'b1, 1'b0},
    '{32'd4,          1'b0, 1'b0},
    '{32'd5,          1'b0, 1'b0},
    '{32'd9,          1'b0, 1'b0},
    '{32'd25,         1'b0, 1'b0},
    '{32'd49,         1'b0, 1'b0},
    '{32'd63001,      1'b0, 1'b0},
    '{32'd65521,      1'b0, 1'b0},
    '{32'd65536,      1'b0, 1'b0},
    '{32'd1000003,    1'b0, 1'b0},
    '{32'h7FFF_FFFD,  1'b0, 1'b0},
    '{32'h7FFF_FFFE,  1'b0, 1'b0},
    '{32'h5555_5555,  1'b0, 1'b0},
    '{32'h2AAA_AAAA,  1'b0, 1'b0},
    '{32'h7FFF_FFFF,  1'b1, 1'b1}
  };

  localparam int unsigned SMALL_FACTORS [10] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31};

  logic  clk;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  word_t value = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  logic  is_prime;

  verdict_t verdict_q[$];
  int       fail_count = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;

  trial_division_prime_test_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_prime  (is_prime)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic is_prime_by_trial(input word_t v);
    longint unsigned n;
    longint unsigned d;
    if (v[VALUE_WIDTH-1]) return 1'b0;
    n = v;
    if (n < 2) return 1'b0;
    for (d = 2; d <= n / d; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned next_prime(input int unsigned start);
    int unsigned n;
    n = start | 1;
    while (!is_prime_by_trial(word_t'(n))) n += 2;
    return n;
  endfunction

  // mostly cheap values; primes and two-prime products kept small so the run stays short
  function automatic word_t random_value();
    int unsigned pick;
    int unsigned p;
    int unsigned q;
    word_t r;
    pick = $urandom_range(0, 99);
    r = $urandom;
    if (pick < 15) begin
      r[VALUE_WIDTH-1] = 1'b1;
      return r;
    end
    if (pick < 30) begin
      r[VALUE_WIDTH-1] = 1'b0;
      r[0] = 1'b0;
      return r;
    end
    if (pick < 50) begin
      p = SMALL_FACTORS[$urandom_range(0, 9)];
      return word_t'(longint'(p) * $urandom_range(2, 32'h7FFF_FFFF / p));
    end
    if (pick < 70) return word_t'($urandom_range(0, 2000));
    if (pick < 85) return word_t'(next_prime($urandom_range(3, 65000)));
    if (pick < 93) begin
      p = next_prime($urandom_range(100, 1500));
      q = next_prime($urandom_range(100, 1500));
      return word_t'(p * q);
    end
    return word_t'(next_prime($urandom_range(65536, 1 << 20)));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic offer(input word_t v, input logic verdict);
    verdict_t entry;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (in_stall);
    entry.value = v;
    entry.is_prime = verdict;
    verdict_q.push_back(entry);
  endtask

  initial begin : stimulus
    stim_row_t row;
    word_t     v;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 29;
    recv_idle_pct = 49;
    for (int i = 0; i < $size(DIRECTED); i++) begin
      row = DIRECTED[i];
      offer(row.value, row.known ? row.verdict : is_prime_by_trial(row.value));
    end
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 30) begin
        send_idle_pct = 49;
        recv_idle_pct = 29;
      end
      if (i == 65) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      v = random_value();
      offer(v, is_prime_by_trial(v));
    end
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : result_check
    verdict_t want;
    int       results_seen;
    int       hold_left;
    results_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result is_prime=%0b with no request pending", is_prime));
        end else begin
          want = verdict_q.pop_front();
          if (is_prime !== want.is_prime)
            report_mismatch($sformatf("value %0d: is_prime=%0b, expected %0b",
                                      $signed(want.value), is_prime, want.is_prime));
        end
        // one long hold-off so the front register and queue fill and in_stall rises
        if (results_seen == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: nothing moved on either channel for %0d cycles", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule
